// ----- hw/rtl/color_filter_matrix_generator_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the colour filter matrix generator
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef COLOR_FILTER_MATRIX_GENERATOR_CORE_MACROS_SVH
`define COLOR_FILTER_MATRIX_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// check a property on the rising edge, ignored while reset is asserted
`define CFM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cfm assertion failed");
// check a property on the rising edge, reset included
`define CFM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cfm assertion failed");
`else
`define CFM_ASSERT(lbl, clk, rstn, prop)
`define CFM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/cfm_pkg.sv -----
// ----------------------------------------------------------------------------
// cfm_pkg
// Types, constants and the matrix entry function of the colour filter
// matrix generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfm_pkg;

  // filter kinds
  typedef enum logic [2:0] {
    FN_OPACITY    = 3'd0,
    FN_BRIGHTNESS = 3'd1,
    FN_CONTRAST   = 3'd2,
    FN_INVERT     = 3'd3,
    FN_GRAYSCALE  = 3'd4,
    FN_SEPIA      = 3'd5,
    FN_HUE        = 3'd6,
    FN_SATURATE   = 3'd7
  } cfm_func_e;

  localparam int unsigned AmtW  = 16;
  localparam int unsigned CoefW = 18;
  localparam int unsigned AngW  = 21;  // amount scaled to Q.16
  localparam int unsigned XW    = 19;  // CORDIC x and y
  localparam int unsigned ZW    = 20;  // CORDIC residual angle
  localparam int unsigned TrigW = 14;  // sine and cosine in Q.12
  localparam int unsigned CvW   = 13;  // clamped invert amount
  localparam int unsigned AccW  = 36;  // Q.24 accumulation
  localparam int unsigned CordicSteps  = 16;
  localparam int unsigned StepsPerStage = 4;

  localparam logic [1:0] ROW_ALPHA = 2'd3;
  localparam logic [1:0] COL_FOURTH = 2'd3;

  localparam logic signed [AngW-1:0] PI_Q16      = 21'sd205887;
  localparam logic signed [AngW-1:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [AngW-1:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [XW-1:0]   CORDIC_X0   = 19'sd39797;

  localparam logic signed [ZW-1:0] CORDIC_ATAN [CordicSteps] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
    20'sd16, 20'sd8, 20'sd4, 20'sd2
  };

  localparam logic signed [AccW-1:0] ONE_Q12  = 36'sd4096;
  localparam logic signed [AccW-1:0] ONE_Q24  = 36'sd16777216;
  localparam logic signed [AccW-1:0] HALF_Q24 = 36'sd8388608;
  localparam logic signed [AccW-1:0] HALF_LSB = 36'sd2048;
  localparam logic signed [AccW-1:0] COEF_MAX = 36'sd131071;
  localparam logic signed [AccW-1:0] COEF_MIN = -36'sd131072;

  localparam logic signed [12:0] LUM_W  [3] = '{13'sd871, 13'sd2929, 13'sd296};
  localparam logic signed [12:0] BASE_W [3] = '{13'sd872, 13'sd2929, 13'sd295};

  localparam logic signed [12:0] SEPIA_W [3][3] = '{
    '{13'sd1610, 13'sd3150, 13'sd774},
    '{13'sd1430, 13'sd2810, 13'sd688},
    '{13'sd1114, 13'sd2187, 13'sd537}
  };

  // cosine (and saturate amount) weights
  localparam logic signed [12:0] HUE_K [3][3] = '{
    '{13'sd3224, -13'sd2929, -13'sd295},
    '{-13'sd872, 13'sd1167, -13'sd295},
    '{-13'sd872, -13'sd2929, 13'sd3801}
  };

  // sine weights
  localparam logic signed [12:0] HUE_S [3][3] = '{
    '{-13'sd872, -13'sd2929, 13'sd3801},
    '{13'sd586, 13'sd573, -13'sd1159},
    '{-13'sd3224, 13'sd2929, 13'sd295}
  };

  // pipeline payload through angle reduction and CORDIC
  typedef struct packed {
    cfm_func_e                func;
    logic signed [AmtW-1:0]   amount;
    logic                     neg;
    logic signed [XW-1:0]     x;
    logic signed [XW-1:0]     y;
    logic signed [ZW-1:0]     z;
  } cfm_stage_t;

  // one matrix entry, rounded to Q.12 and saturated
  function automatic logic signed [CoefW-1:0] cfm_entry(
    input cfm_func_e               f,
    input logic [1:0]              r,
    input logic [1:0]              c,
    input logic signed [AmtW-1:0]  v,
    input logic [CvW-1:0]          cv,
    input logic signed [TrigW-1:0] s,
    input logic signed [TrigW-1:0] k
  );
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] vx;
    logic signed [AccW-1:0] cvx;
    logic signed [AccW-1:0] sx;
    logic signed [AccW-1:0] kx;
    logic signed [AccW-1:0] rnd;
    logic                   diag;
    logic                   rgb;
    vx   = AccW'(v);
    cvx  = AccW'(cv);
    sx   = AccW'(s);
    kx   = AccW'(k);
    diag = (r == c);
    rgb  = (r != ROW_ALPHA) && (c != COL_FOURTH);
    acc  = diag ? ONE_Q24 : '0;
    case (f)
      FN_OPACITY: begin
        if (r == ROW_ALPHA && c == COL_FOURTH) acc = vx <<< 12;
      end
      FN_BRIGHTNESS: begin
        if (r != ROW_ALPHA && diag) acc = vx <<< 12;
      end
      FN_CONTRAST: begin
        if (r != ROW_ALPHA && diag) acc = vx <<< 12;
        if (r != ROW_ALPHA && c == COL_FOURTH) acc = HALF_Q24 - (vx <<< 11);
      end
      FN_INVERT: begin
        if (r != ROW_ALPHA && diag) acc = (ONE_Q12 - (cvx <<< 1)) <<< 12;
        if (r != ROW_ALPHA && c == COL_FOURTH) acc = cvx <<< 12;
      end
      FN_GRAYSCALE: begin
        if (rgb) begin
          acc = vx * AccW'(LUM_W[c]);
          if (diag) acc = acc + ((ONE_Q12 - vx) <<< 12);
        end
      end
      FN_SEPIA: begin
        if (rgb) begin
          acc = vx * AccW'(SEPIA_W[r][c]);
          if (diag) acc = acc + ((ONE_Q12 - vx) <<< 12);
        end
      end
      FN_HUE: begin
        if (rgb) begin
          acc = (AccW'(BASE_W[c]) <<< 12) + kx * AccW'(HUE_K[r][c])
              + sx * AccW'(HUE_S[r][c]);
        end
      end
      FN_SATURATE: begin
        if (rgb) acc = (AccW'(BASE_W[c]) <<< 12) + vx * AccW'(HUE_K[r][c]);
      end
      default: acc = diag ? ONE_Q24 : '0;
    endcase
    rnd = (acc + HALF_LSB) >>> 12;
    if (rnd > COEF_MAX) rnd = COEF_MAX;
    if (rnd < COEF_MIN) rnd = COEF_MIN;
    return rnd[CoefW-1:0];
  endfunction

endpackage

// ----- hw/rtl/cfm_if.sv -----
// ----------------------------------------------------------------------------
// cfm_if
// Valid/ready channels for requests and matrix rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfm_req_if;
  logic                       valid;
  logic                       ready;
  cfm_pkg::cfm_func_e         func;
  logic signed [15:0]         amount;

  modport source (output valid, output func, output amount, input ready);
  modport sink   (input valid, input func, input amount, output ready);
endinterface

interface cfm_row_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 row_index;
  logic signed [17:0]         coef_red;
  logic signed [17:0]         coef_green;
  logic signed [17:0]         coef_blue;
  logic signed [17:0]         coef_fourth;
  logic                       last_row;

  modport source (output valid, output row_index, output coef_red, output coef_green,
                  output coef_blue, output coef_fourth, output last_row, input ready);
  modport sink   (input valid, input row_index, input coef_red, input coef_green,
                  input coef_blue, input coef_fourth, input last_row, output ready);
endinterface

// ----- hw/rtl/cfm_prep.sv -----
// ----------------------------------------------------------------------------
// cfm_prep
// Entry stage: scale the amount to a Q.16 angle and fold it into
// [-pi/2, pi/2] ahead of the CORDIC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfm_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cfm_pkg::cfm_func_e   func_i,
  input  logic signed [15:0]   amount_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cfm_pkg::cfm_stage_t  stage_o
);
  import cfm_pkg::*;

  logic                   valid_q;
  logic                   valid_d;
  cfm_stage_t             stage_q;
  cfm_stage_t             stage_d;
  logic signed [AngW-1:0] ang0;
  logic signed [AngW-1:0] ang1;
  logic signed [AngW-1:0] ang2;
  logic                   neg;

  assign ready_o = !valid_q || ready_i;

  // fold the angle: first into [-pi, pi], then into [-pi/2, pi/2]
  always_comb begin
    ang0 = AngW'(amount_i) <<< 4;
    if (ang0 > PI_Q16) begin
      ang1 = ang0 - TWO_PI_Q16;
    end else if (ang0 < -PI_Q16) begin
      ang1 = ang0 + TWO_PI_Q16;
    end else begin
      ang1 = ang0;
    end
    neg = 1'b0;
    if (ang1 > HALF_PI_Q16) begin
      ang2 = ang1 - PI_Q16;
      neg  = 1'b1;
    end else if (ang1 < -HALF_PI_Q16) begin
      ang2 = ang1 + PI_Q16;
      neg  = 1'b1;
    end else begin
      ang2 = ang1;
    end
    stage_d.func   = func_i;
    stage_d.amount = amount_i;
    stage_d.neg    = neg;
    stage_d.x      = CORDIC_X0;
    stage_d.y      = '0;
    stage_d.z      = ang2[ZW-1:0];
  end

  // hold when stalled, advance otherwise
  always_comb begin
    valid_d = valid_q;
    if (ready_o) valid_d = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- hw/rtl/cfm_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// cfm_cordic_stage
// One register stage of the rotation-mode CORDIC, running a group of
// consecutive micro-rotations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfm_cordic_stage #(
  parameter int unsigned FirstStep = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cfm_pkg::cfm_stage_t  stage_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cfm_pkg::cfm_stage_t  stage_o
);
  import cfm_pkg::*;

  logic                 valid_q;
  logic                 valid_d;
  cfm_stage_t           stage_q;
  cfm_stage_t           stage_d;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign ready_o = !valid_q || ready_i;

  // run the micro-rotations of this stage
  always_comb begin
    stage_d = stage_i;
    for (int j = 0; j < StepsPerStage; j++) begin
      dx = stage_d.y >>> (FirstStep + j);
      dy = stage_d.x >>> (FirstStep + j);
      if (!stage_d.z[ZW-1]) begin
        stage_d.x = stage_d.x - dx;
        stage_d.y = stage_d.y + dy;
        stage_d.z = stage_d.z - CORDIC_ATAN[4'(FirstStep + j)];
      end else begin
        stage_d.x = stage_d.x + dx;
        stage_d.y = stage_d.y - dy;
        stage_d.z = stage_d.z + CORDIC_ATAN[4'(FirstStep + j)];
      end
    end
  end

  // hold when stalled, advance otherwise
  always_comb begin
    valid_d = valid_q;
    if (ready_o) valid_d = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- hw/rtl/cfm_row_gen.sv -----
// ----------------------------------------------------------------------------
// cfm_row_gen
// Rounds sine and cosine, holds one request and emits its four matrix rows
// through an output register, one row per cycle while ready_i is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfm_row_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cfm_pkg::cfm_stage_t  stage_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [1:0]           row_index_o,
  output logic signed [17:0]   coef_red_o,
  output logic signed [17:0]   coef_green_o,
  output logic signed [17:0]   coef_blue_o,
  output logic signed [17:0]   coef_fourth_o,
  output logic                 last_row_o
);
  import cfm_pkg::*;

  logic                    hold_valid_q;
  logic                    hold_valid_d;
  logic [1:0]              row_q;
  logic [1:0]              row_d;
  cfm_func_e               func_q;
  logic signed [AmtW-1:0]  amount_q;
  logic [CvW-1:0]          cv_q;
  logic [CvW-1:0]          cv_d;
  logic signed [TrigW-1:0] sin_q;
  logic signed [TrigW-1:0] sin_d;
  logic signed [TrigW-1:0] cos_q;
  logic signed [TrigW-1:0] cos_d;
  logic signed [XW:0]      x_rnd;
  logic signed [XW:0]      y_rnd;
  logic                    take;
  logic                    emit;
  logic                    last;
  logic                    out_valid_q;
  logic                    out_valid_d;
  logic [1:0]              out_row_q;
  logic signed [CoefW-1:0] out_coef_q [4];
  logic signed [CoefW-1:0] coef_d [4];

  assign emit    = hold_valid_q && (!out_valid_q || ready_i);
  assign last    = (row_q == ROW_ALPHA);
  assign ready_o = !hold_valid_q || (emit && last);
  assign take    = valid_i && ready_o;

  // round sine and cosine to Q.12, undo the half-turn fold, clamp invert
  always_comb begin
    x_rnd = ((XW + 1)'(stage_i.x) + (XW + 1)'(8)) >>> 4;
    y_rnd = ((XW + 1)'(stage_i.y) + (XW + 1)'(8)) >>> 4;
    cos_d = stage_i.neg ? -x_rnd[TrigW-1:0] : x_rnd[TrigW-1:0];
    sin_d = stage_i.neg ? -y_rnd[TrigW-1:0] : y_rnd[TrigW-1:0];
    if (stage_i.amount < 0) begin
      cv_d = '0;
    end else if (stage_i.amount > AmtW'(ONE_Q12)) begin
      cv_d = CvW'(ONE_Q12);
    end else begin
      cv_d = stage_i.amount[CvW-1:0];
    end
  end

  // build the four entries of the current row
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      coef_d[c] = cfm_entry(func_q, row_q, 2'(c), amount_q, cv_q, sin_q, cos_q);
    end
  end

  // advance the hold slot, row counter and output register
  always_comb begin
    hold_valid_d = hold_valid_q;
    if (emit && last) hold_valid_d = 1'b0;
    if (take) hold_valid_d = 1'b1;
    row_d = emit ? row_q + 2'd1 : row_q;
    out_valid_d = out_valid_q;
    if (ready_i) out_valid_d = 1'b0;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      row_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      row_q        <= row_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q   <= stage_i.func;
      amount_q <= stage_i.amount;
      cv_q     <= cv_d;
      sin_q    <= sin_d;
      cos_q    <= cos_d;
    end
    if (emit) begin
      out_row_q  <= row_q;
      out_coef_q <= coef_d;
    end
  end

  assign valid_o       = out_valid_q;
  assign row_index_o   = out_row_q;
  assign coef_red_o    = out_coef_q[0];
  assign coef_green_o  = out_coef_q[1];
  assign coef_blue_o   = out_coef_q[2];
  assign coef_fourth_o = out_coef_q[3];
  assign last_row_o    = (out_row_q == ROW_ALPHA);

endmodule

// ----- hw/rtl/color_filter_matrix_generator_core.sv -----
// Colour filter matrix generator. Each request (filter kind, signed Q4.12
// amount) returns four row transactions, red, green, blue and alpha, of a 4x4
// matrix in signed Q6.12; the fourth column carries the offsets and the alpha
// scale. One row leaves per cycle while the row channel is ready, and the
// single row builder that serialises each matrix takes a new request only
// when it is empty or as it emits the last row of the held one. A request
// enters the angle-folding stage at the accepting edge, then passes four
// CORDIC stages of four micro-rotations each, the request hold slot and the
// output register. Stalls on the row channel back-pressure the whole
// pipeline without loss.
// ----------------------------------------------------------------------------
// color_filter_matrix_generator_core
// Top level: angle folding, pipelined CORDIC and row generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "color_filter_matrix_generator_core_macros.svh"

module color_filter_matrix_generator_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  cfm_req_if.sink   req_i,
  cfm_row_if.source row_o
);
  import cfm_pkg::*;

  localparam int unsigned NumCordic = CordicSteps / StepsPerStage;

  logic       valid [NumCordic+1];
  logic       ready [NumCordic+1];
  cfm_stage_t stage [NumCordic+1];

  // angle folding
  cfm_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (req_i.valid),
    .ready_o  (req_i.ready),
    .func_i   (req_i.func),
    .amount_i (req_i.amount),
    .valid_o  (valid[0]),
    .ready_i  (ready[0]),
    .stage_o  (stage[0])
  );

  // CORDIC stages
  for (genvar g = 0; g < NumCordic; g++) begin : g_cordic
    cfm_cordic_stage #(
      .FirstStep (g * StepsPerStage)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[g]),
      .ready_o (ready[g]),
      .stage_i (stage[g]),
      .valid_o (valid[g+1]),
      .ready_i (ready[g+1]),
      .stage_o (stage[g+1])
    );
  end

  // row builder and output register
  cfm_row_gen u_row_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid[NumCordic]),
    .ready_o       (ready[NumCordic]),
    .stage_i       (stage[NumCordic]),
    .valid_o       (row_o.valid),
    .ready_i       (row_o.ready),
    .row_index_o   (row_o.row_index),
    .coef_red_o    (row_o.coef_red),
    .coef_green_o  (row_o.coef_green),
    .coef_blue_o   (row_o.coef_blue),
    .coef_fourth_o (row_o.coef_fourth),
    .last_row_o    (row_o.last_row)
  );

  // last-row flag marks the alpha row only
  `CFM_ASSERT(a_last_is_alpha, clk_i, rst_ni, row_o.valid |-> (row_o.last_row == (row_o.row_index == ROW_ALPHA)))
  // rows of one matrix follow back to back, in order
  `CFM_ASSERT(a_rows_in_order, clk_i, rst_ni, (row_o.valid && row_o.ready && !row_o.last_row) |=> (row_o.valid && row_o.row_index == $past(row_o.row_index) + 2'd1))
  // no row is offered while in reset
  `CFM_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |-> !row_o.valid)

endmodule
